FILE: hw/rtl/mlqs_pkg.sv
// ----------------------------------------------------------------------------
// mlqs_pkg
// shared types and constants of the multilevel queue quantum scheduler
// ----------------------------------------------------------------------------
package mlqs_pkg;

  localparam int unsigned LEVELS_DEF = 4;
  localparam int unsigned PROCS_DEF  = 16;

  localparam logic [7:0] QUANTUM_RST = 8'd3;
  localparam logic [1:0] PREEMPT_RST = 2'd1;

  localparam logic [1:0] MODE_ADMIT = 2'd0;
  localparam logic [1:0] MODE_SCHED = 2'd1;
  localparam logic [1:0] MODE_BLOCK = 2'd2;
  localparam logic [1:0] MODE_TICK  = 2'd3;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_TERM    = 2'd1;
  localparam logic [1:0] EV_PREEMPT = 2'd2;
  localparam logic [1:0] EV_FULL    = 2'd3;

  localparam logic REG_QUANTUM = 1'b0;
  localparam logic REG_PREEMPT = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_e;

endpackage

FILE: hw/rtl/multilevel_queue_quantum_scheduler_top.sv
// ----------------------------------------------------------------------------
// multilevel_queue_quantum_scheduler_top
// per-level fifos of process ids in one queue memory, running process and
// quantum tracking
// ----------------------------------------------------------------------------
// A command is taken when start_i is high and busy_o is low; its queue push
// and head read go to the queue memory in that cycle, and busy_o is high in
// the following cycle while the registered read data settles the running
// process. The result appears on the output ports for exactly one cycle with
// done_o high, in the cycle after busy_o, and the next command may be started
// in that same cycle; no command is taken while busy_o is high. The response
// cycle is needed because the queue memory read is registered. Results cannot
// be held off by the receiver. Configuration writes (cfg_we_i) take effect at
// once and are meant for idle times only.
module multilevel_queue_quantum_scheduler_top
  import mlqs_pkg::*;
#(
  parameter int unsigned LEVELS = LEVELS_DEF,
  parameter int unsigned PROCS  = PROCS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] mode_i,
  input  logic [3:0] process_id_i,
  input  logic [1:0] priority_req_i,
  input  logic       has_work_i,
  input  logic       cfg_we_i,
  input  logic       cfg_addr_i,
  input  logic [7:0] cfg_wdata_i,
  output logic       done_o,
  output logic       current_valid_o,
  output logic [3:0] current_id_o,
  output logic [1:0] event_res_o,
  output logic [3:0] event_id_o,
  output logic       dispatched_o
);

  localparam int unsigned LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned PW    = (PROCS > 1) ? $clog2(PROCS) : 1;
  localparam int unsigned CW    = $clog2(PROCS + 1);
  localparam int unsigned DEPTH = LEVELS * (1 << PW);

  function automatic logic [LW-1:0] clamp_lvl(input logic [1:0] lv);
    if (32'(lv) >= LEVELS) begin
      return LW'(LEVELS - 1);
    end else begin
      return LW'(lv);
    end
  endfunction

  state_e state_q, state_d;

  logic [PW-1:0] head_q  [LEVELS];
  logic [PW-1:0] head_d  [LEVELS];
  logic [PW-1:0] tail_q  [LEVELS];
  logic [PW-1:0] tail_d  [LEVELS];
  logic [CW-1:0] count_q [LEVELS];
  logic [CW-1:0] count_d [LEVELS];

  logic       run_valid_q, run_valid_d;
  logic [3:0] run_id_q, run_id_d;
  logic [7:0] time_used_q, time_used_d;
  logic [7:0] quantum_q;
  logic [1:0] preempt_q;

  logic       take_q, found_q, fwd_q, done_q;
  logic [3:0] fwd_id_q;
  logic [1:0] ev_q;
  logic [3:0] ev_id_q;

  logic [3:0] mem [DEPTH];
  logic [3:0] rd_data_q;

  logic          acc;
  logic          want_push, want_take, is_preempt, full, do_push, found, fwd;
  logic [LW-1:0] push_lv, rd_lvl, wr_lvl;
  logic [3:0]    push_id;
  logic [CW-1:0] push_cnt, cnt_after;
  logic [PW-1:0] rd_idx, wr_idx;
  logic [LEVELS-1:0] push_oh, take_oh;
  logic [1:0]    ev;
  logic [3:0]    ev_id;

  assign acc = start_i && (state_q == ST_IDLE);

  always_comb begin
    want_push  = 1'b0;
    want_take  = 1'b0;
    is_preempt = 1'b0;
    push_lv    = '0;
    push_id    = process_id_i;
    ev         = EV_NONE;
    ev_id      = '0;
    time_used_d = time_used_q;
    if (acc) begin
      case (mode_i)
        MODE_ADMIT: begin
          if (!has_work_i) begin
            ev    = EV_TERM;
            ev_id = process_id_i;
          end else begin
            want_push = 1'b1;
            push_lv   = clamp_lvl(priority_req_i);
          end
        end
        MODE_SCHED: begin
          if (!run_valid_q) begin
            want_take = 1'b1;
          end else if (!has_work_i) begin
            ev        = EV_TERM;
            ev_id     = run_id_q;
            want_take = 1'b1;
          end else if (time_used_q >= quantum_q) begin
            want_push  = 1'b1;
            is_preempt = 1'b1;
            push_lv    = clamp_lvl(preempt_q);
            push_id    = run_id_q;
            ev_id      = run_id_q;
            want_take  = 1'b1;
          end
        end
        MODE_BLOCK: want_take = 1'b1;
        MODE_TICK: begin
          if (time_used_q != 8'hff) begin
            time_used_d = time_used_q + 8'd1;
          end
        end
        default: ;
      endcase
      if (want_take) begin
        time_used_d = '0;
      end
    end

    push_cnt = '0;
    for (int lv = 0; lv < LEVELS; lv++) begin
      if (push_lv == LW'(lv)) begin
        push_cnt = push_cnt | count_q[lv];
      end
    end
    full    = (push_cnt == CW'(PROCS));
    do_push = want_push && !full;
    if (want_push && full) begin
      ev    = EV_FULL;
      ev_id = push_id;
    end else if (is_preempt) begin
      ev = EV_PREEMPT;
    end

    found  = 1'b0;
    fwd    = 1'b0;
    rd_idx = '0;
    rd_lvl = '0;
    wr_idx = '0;
    wr_lvl = '0;
    for (int lv = 0; lv < LEVELS; lv++) begin
      push_oh[lv] = do_push && (push_lv == LW'(lv));
      cnt_after   = count_q[lv] + CW'(push_oh[lv]);
      take_oh[lv] = 1'b0;
      if (want_take && !found && (cnt_after != '0)) begin
        take_oh[lv] = 1'b1;
        found       = 1'b1;
      end
      if (take_oh[lv]) begin
        rd_idx = rd_idx | head_q[lv];
        rd_lvl = rd_lvl | LW'(lv);
        fwd    = fwd | (push_oh[lv] && (count_q[lv] == '0));
      end
      if (push_oh[lv]) begin
        wr_idx = wr_idx | tail_q[lv];
        wr_lvl = wr_lvl | LW'(lv);
      end
      head_d[lv]  = head_q[lv];
      tail_d[lv]  = tail_q[lv];
      count_d[lv] = cnt_after - CW'(take_oh[lv]);
      if (take_oh[lv]) begin
        head_d[lv] = (head_q[lv] == PW'(PROCS - 1)) ? '0 : head_q[lv] + PW'(1);
      end
      if (push_oh[lv]) begin
        tail_d[lv] = (tail_q[lv] == PW'(PROCS - 1)) ? '0 : tail_q[lv] + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[{wr_lvl, wr_idx}] <= push_id;
    end
    rd_data_q <= mem[{rd_lvl, rd_idx}];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start_i) state_d = ST_RESP;
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o      = 1'b0;
    run_valid_d = run_valid_q;
    run_id_d    = run_id_q;
    case (state_q)
      ST_IDLE: busy_o = 1'b0;
      ST_RESP: begin
        busy_o = 1'b1;
        if (take_q) begin
          run_valid_d = found_q;
          run_id_d    = !found_q ? 4'd0 : (fwd_q ? fwd_id_q : rd_data_q);
        end
      end
      default: busy_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_valid_q <= 1'b0;
      run_id_q    <= '0;
      time_used_q <= '0;
      quantum_q   <= QUANTUM_RST;
      preempt_q   <= PREEMPT_RST;
      take_q      <= 1'b0;
      found_q     <= 1'b0;
      fwd_q       <= 1'b0;
      done_q      <= 1'b0;
      for (int lv = 0; lv < LEVELS; lv++) begin
        head_q[lv]  <= '0;
        tail_q[lv]  <= '0;
        count_q[lv] <= '0;
      end
    end else begin
      state_q     <= state_d;
      run_valid_q <= run_valid_d;
      run_id_q    <= run_id_d;
      time_used_q <= time_used_d;
      done_q      <= (state_q == ST_RESP);
      if (acc) begin
        take_q  <= want_take;
        found_q <= found;
        fwd_q   <= fwd;
      end
      for (int lv = 0; lv < LEVELS; lv++) begin
        head_q[lv]  <= head_d[lv];
        tail_q[lv]  <= tail_d[lv];
        count_q[lv] <= count_d[lv];
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_QUANTUM: quantum_q <= cfg_wdata_i;
          REG_PREEMPT: preempt_q <= cfg_wdata_i[1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      ev_q     <= ev;
      ev_id_q  <= ev_id;
      fwd_id_q <= push_id;
    end
    if (state_q == ST_RESP) begin
      current_valid_o <= run_valid_d;
      current_id_o    <= run_valid_d ? run_id_d : 4'd0;
      event_res_o     <= ev_q;
      event_id_o      <= ev_id_q;
      dispatched_o    <= take_q && found_q;
    end
  end

  assign done_o = done_q;

  a_resp_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP) |=> done_o)
    else $error("result transfer missing after response cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("accepted command did not enter response cycle");

  a_idle_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !current_valid_o) |-> (current_id_o == 4'd0 && !dispatched_o))
    else $error("idle result carries a process id or dispatch");

  a_no_event_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && event_res_o == EV_NONE) |-> (event_id_o == 4'd0))
    else $error("event id set without an event");

endmodule

FILE: tb/mlqs_sched_checker.sv
// ----------------------------------------------------------------------------
// mlqs_sched_checker
// watches the command and result ports of the multilevel queue scheduler,
// keeps its own copy of the level queues, running process and used-time
// count, predicts one result per accepted command and compares it field by
// field with the next result the block returns
// ----------------------------------------------------------------------------
module mlqs_sched_checker
  import mlqs_pkg::*;
#(
  parameter int unsigned LEVELS = LEVELS_DEF,
  parameter int unsigned PROCS  = PROCS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  mode_i,
  input  logic [3:0]  process_id_i,
  input  logic [1:0]  priority_req_i,
  input  logic        has_work_i,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        done_i,
  input  logic        current_valid_i,
  input  logic [3:0]  current_id_i,
  input  logic [1:0]  event_res_i,
  input  logic [3:0]  event_id_i,
  input  logic        dispatched_i,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       cur_valid;
    logic [3:0] cur_id;
    logic [1:0] ev;
    logic [3:0] ev_id;
    logic       disp;
  } sched_result_t;

  logic [3:0]    level_slots [LEVELS][PROCS];
  int unsigned   level_head [LEVELS];
  int unsigned   level_tail [LEVELS];
  int unsigned   level_fill [LEVELS];
  logic          run_valid;
  logic [3:0]    run_id;
  logic [7:0]    used_units;
  logic [7:0]    quantum;
  logic [1:0]    preempt_lvl;
  sched_result_t sched_results_q [$];
  int unsigned   mismatch_cnt;

  function automatic int unsigned clamp_level(logic [1:0] lv);
    return (lv >= LEVELS) ? LEVELS - 1 : lv;
  endfunction

  function automatic bit push_level(int unsigned lv, logic [3:0] id);
    if (level_fill[lv] >= PROCS) return 1'b0;
    level_slots[lv][level_tail[lv]] = id;
    level_tail[lv] = (level_tail[lv] + 1 >= PROCS) ? 0 : level_tail[lv] + 1;
    level_fill[lv]++;
    return 1'b1;
  endfunction

  function automatic bit take_next();
    used_units = '0;
    for (int unsigned lv = 0; lv < LEVELS; lv++) begin
      if (level_fill[lv] != 0) begin
        run_id = level_slots[lv][level_head[lv]];
        level_head[lv] = (level_head[lv] + 1 >= PROCS) ? 0 : level_head[lv] + 1;
        level_fill[lv]--;
        run_valid = 1'b1;
        return 1'b1;
      end
    end
    run_valid = 1'b0;
    run_id = '0;
    return 1'b0;
  endfunction

  function automatic sched_result_t apply_command(logic [1:0] mode, logic [3:0] pid,
                                                  logic [1:0] prio, logic work);
    sched_result_t r;
    r = '0;
    case (mode)
      MODE_ADMIT: begin
        if (!work) begin
          r.ev    = EV_TERM;
          r.ev_id = pid;
        end else if (!push_level(clamp_level(prio), pid)) begin
          r.ev    = EV_FULL;
          r.ev_id = pid;
        end
      end
      MODE_SCHED: begin
        if (!run_valid) begin
          r.disp = take_next();
        end else if (!work) begin
          r.ev    = EV_TERM;
          r.ev_id = run_id;
          r.disp  = take_next();
        end else if (used_units >= quantum) begin
          r.ev_id = run_id;
          r.ev    = push_level(clamp_level(preempt_lvl), run_id) ? EV_PREEMPT : EV_FULL;
          r.disp  = take_next();
        end
      end
      MODE_BLOCK: begin
        r.disp = take_next();
      end
      default: begin
        if (used_units != 8'hff) used_units++;
      end
    endcase
    r.cur_valid = run_valid;
    r.cur_id    = run_valid ? run_id : '0;
    return r;
  endfunction

  task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t want;
    if (!rst_ni) begin
      for (int unsigned lv = 0; lv < LEVELS; lv++) begin
        for (int unsigned s = 0; s < PROCS; s++) level_slots[lv][s] = '0;
        level_head[lv] = 0;
        level_tail[lv] = 0;
        level_fill[lv] = 0;
      end
      run_valid    = 1'b0;
      run_id       = '0;
      used_units   = '0;
      quantum      = QUANTUM_RST;
      preempt_lvl  = PREEMPT_RST;
      mismatch_cnt = 0;
      sched_results_q.delete();
    end else begin
      if (done_i) begin
        if (sched_results_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: result with no transfer pending, expected none, actual %b %0d %0d %0d %b",
                   $time, current_valid_i, current_id_i, event_res_i, event_id_i,
                   dispatched_i);
        end else begin
          want = sched_results_q.pop_front();
          check_field("current_valid", 4'(want.cur_valid), 4'(current_valid_i));
          check_field("current_id", want.cur_id, current_id_i);
          check_field("event_res", 4'(want.ev), 4'(event_res_i));
          check_field("event_id", want.ev_id, event_id_i);
          check_field("dispatched", 4'(want.disp), 4'(dispatched_i));
        end
      end
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_QUANTUM) quantum = cfg_wdata_i;
        else preempt_lvl = cfg_wdata_i[1:0];
      end
      if (start_i && !busy_i) begin
        sched_results_q.push_back(apply_command(mode_i, process_id_i, priority_req_i,
                                                has_work_i));
      end
    end
    fail_count_o  <= mismatch_cnt;
    outstanding_o <= sched_results_q.size();
  end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives commands and register writes into the multilevel queue scheduler:
// directed commands for the corner cases and phases of random commands
// under several quantum and preempt level settings with random start gaps;
// results are checked by mlqs_sched_checker
// ----------------------------------------------------------------------------
module tb_top
  import mlqs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  mode_i;
  logic [3:0]  process_id_i;
  logic [1:0]  priority_req_i;
  logic        has_work_i;
  logic        cfg_we_i;
  logic        cfg_addr_i;
  logic [7:0]  cfg_wdata_i;
  logic        done_o;
  logic        current_valid_o;
  logic [3:0]  current_id_o;
  logic [1:0]  event_res_o;
  logic [3:0]  event_id_o;
  logic        dispatched_o;
  int unsigned fail_count;
  int unsigned outstanding;
  bit          no_gaps;

  multilevel_queue_quantum_scheduler_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .process_id_i   (process_id_i),
    .priority_req_i (priority_req_i),
    .has_work_i     (has_work_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .current_valid_o(current_valid_o),
    .current_id_o   (current_id_o),
    .event_res_o    (event_res_o),
    .event_id_o     (event_id_o),
    .dispatched_o   (dispatched_o)
  );

  mlqs_sched_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .mode_i         (mode_i),
    .process_id_i   (process_id_i),
    .priority_req_i (priority_req_i),
    .has_work_i     (has_work_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_i         (done_o),
    .current_valid_i(current_valid_o),
    .current_id_i   (current_id_o),
    .event_res_i    (event_res_o),
    .event_id_i     (event_id_o),
    .dispatched_i   (dispatched_o),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // start stays high between back-to-back commands
  task automatic issue(logic [1:0] mode, logic [3:0] pid, logic [1:0] prio, logic work);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    mode_i         <= mode;
    process_id_i   <= pid;
    priority_req_i <= prio;
    has_work_i     <= work;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic random_command();
    int unsigned pick;
    logic [1:0]  mode;
    logic [3:0]  pid;
    logic [1:0]  prio;
    pick = $urandom_range(0, 99);
    pid  = 4'($urandom_range(0, 15));
    prio = 2'($urandom_range(0, 3));
    if (pick < 35) mode = MODE_ADMIT;
    else if (pick < 65) mode = MODE_SCHED;
    else if (pick < 75) mode = MODE_BLOCK;
    else mode = MODE_TICK;
    issue(mode, pid, prio, $urandom_range(0, 4) != 0);
  endtask

  // wait until every transfer has its result, with start held low
  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(logic [7:0] q, logic [1:0] lvl);
    logic [5:0] upper;
    upper = 6'($urandom_range(0, 63));
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_QUANTUM;
    cfg_wdata_i <= q;
    @(posedge clk_i);
    cfg_addr_i  <= REG_PREEMPT;
    cfg_wdata_i <= {upper, lvl};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_phase(int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 30 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      random_command();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    logic [7:0] q;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    mode_i         = MODE_ADMIT;
    process_id_i   = '0;
    priority_req_i = '0;
    has_work_i     = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_addr_i     = REG_QUANTUM;
    cfg_wdata_i    = '0;
    no_gaps        = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: idle commands, admit on every level, quantum use
    issue(MODE_SCHED, 4'd0, 2'd0, 1'b1);
    issue(MODE_BLOCK, 4'd0, 2'd0, 1'b0);
    issue(MODE_TICK, 4'd0, 2'd0, 1'b0);
    issue(MODE_ADMIT, 4'd0, 2'd0, 1'b0);
    issue(MODE_ADMIT, 4'd15, 2'd3, 1'b1);
    issue(MODE_ADMIT, 4'd5, 2'd2, 1'b1);
    issue(MODE_ADMIT, 4'd9, 2'd1, 1'b1);
    issue(MODE_ADMIT, 4'd3, 2'd0, 1'b1);
    issue(MODE_SCHED, 4'd0, 2'd0, 1'b1);
    issue(MODE_SCHED, 4'd15, 2'd3, 1'b1);
    issue(MODE_TICK, 4'd15, 2'd3, 1'b1);
    issue(MODE_TICK, 4'd0, 2'd0, 1'b0);
    issue(MODE_TICK, 4'd0, 2'd0, 1'b1);
    issue(MODE_SCHED, 4'd0, 2'd0, 1'b1);
    issue(MODE_SCHED, 4'd0, 2'd0, 1'b0);
    issue(MODE_BLOCK, 4'd15, 2'd3, 1'b1);
    issue(MODE_ADMIT, 4'd10, 2'd0, 1'b1);
    issue(MODE_SCHED, 4'd0, 2'd0, 1'b0);
    issue(MODE_BLOCK, 4'd0, 2'd0, 1'b1);
    issue(MODE_BLOCK, 4'd0, 2'd0, 1'b1);
    issue(MODE_BLOCK, 4'd0, 2'd0, 1'b1);
    issue(MODE_ADMIT, 4'd12, 2'd3, 1'b0);
    issue(MODE_ADMIT, 4'd6, 2'd1, 1'b1);
    issue(MODE_SCHED, 4'd6, 2'd1, 1'b1);
    settle();

    // zero quantum: every schedule with work for a running process preempts
    set_config(8'd0, 2'd3);
    random_phase(60);
    settle();

    // largest quantum, used-time count saturates
    set_config(8'd255, 2'd0);
    issue(MODE_ADMIT, 4'd7, 2'd3, 1'b1);
    issue(MODE_BLOCK, 4'd0, 2'd0, 1'b1);
    no_gaps = 1'b1;
    repeat (260) issue(MODE_TICK, 4'd0, 2'd0, 1'b1);
    no_gaps = 1'b0;
    issue(MODE_SCHED, 4'd0, 2'd0, 1'b1);
    issue(MODE_TICK, 4'd0, 2'd0, 1'b1);
    settle();

    // full queue on admit and on preempt
    set_config(8'd1, 2'd2);
    for (int unsigned n = 0; n < 17; n++) issue(MODE_ADMIT, 4'(n), 2'd2, 1'b1);
    issue(MODE_ADMIT, 4'd14, 2'd0, 1'b1);
    issue(MODE_BLOCK, 4'd0, 2'd0, 1'b1);
    issue(MODE_TICK, 4'd0, 2'd0, 1'b1);
    issue(MODE_SCHED, 4'd0, 2'd0, 1'b1);
    settle();

    repeat (4) begin
      if ($urandom_range(0, 3) == 0) q = 8'($urandom_range(0, 255));
      else q = 8'($urandom_range(1, 6));
      set_config(q, 2'($urandom_range(0, 3)));
      random_phase(20);
      settle();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/mlqs_pkg.sv
hw/rtl/multilevel_queue_quantum_scheduler_top.sv
tb/mlqs_sched_checker.sv
tb/tb_top.sv
